/* design/wchc_pkg.sv */
// Package for the wire chamber hit centroid block: field widths, register
// indexes, reset values, sequencer states and the structs between modules.
// No dependencies.
package wchc_pkg;

    // Fixed field widths of the ports.
    localparam int CHANNEL_W = 8;
    localparam int CHARGE_W  = 16;
    localparam int TIME_W    = 32;
    localparam int POS_W     = 8;
    localparam int HITS_W    = 5;
    localparam int GAP_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_AXIS_HITS = 10;
    localparam int DEF_CHARGE_BITS   = 16;
    localparam int DEF_TIME_BITS     = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HITS  = 2'd3;

    // Configuration reset values.
    localparam logic [GAP_W-1:0]     GAP_LIMIT_RESET = 16'd80;
    localparam logic [CHANNEL_W-1:0] Y_BASE_RESET    = 8'd100;
    localparam logic [HITS_W-1:0]    MIN_HITS_RESET  = 5'd2;
    localparam logic [HITS_W-1:0]    MAX_HITS_RESET  = 5'd20;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CLOSE,
        ST_START_X,
        ST_WAIT_X,
        ST_START_Y,
        ST_WAIT_Y,
        ST_OUT
    } state_t;

    // Commands from the sequencer to the accumulator.
    typedef struct packed {
        logic load;
        logic add;
        logic close;
    } accum_ctrl_t;

    // Status from the accumulator to the sequencer.
    typedef struct packed {
        logic emit;
        logic close_hit;
    } accum_status_t;

endpackage

/* design/wire_chamber_hit_centroid.sv */
// Top level of the wire chamber hit centroid block: configuration registers,
// sequencer and output register. Uses wchc_accum and wchc_div, and wchc_pkg.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_stall   channel, charge, hit_time, last_in_pulse
// out      out  out_valid / out_stall x_position, y_position, event_time
// cfg      in   cfg_write             cfg_index, cfg_data
//
// After a hit is accepted the sequencer passes its add and close states before
// the next hit can be taken. A hit that closes a cluster giving an event also
// runs the shared divider, which produces one quotient bit per cycle, first X
// then Y. Reset is asynchronous and clears all control state and the cluster.
// The input is stalled while a hit is in work; a stalled output beat holds
// its register, and the sequencer waits on it only when a new event is ready.
module wire_chamber_hit_centroid #(
    parameter int MAX_AXIS_HITS = wchc_pkg::DEF_MAX_AXIS_HITS,
    parameter int CHARGE_BITS   = wchc_pkg::DEF_CHARGE_BITS,
    parameter int TIME_BITS     = wchc_pkg::DEF_TIME_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [wchc_pkg::CHANNEL_W-1:0] channel,
    input  logic [wchc_pkg::CHARGE_W-1:0]  charge,
    input  logic [wchc_pkg::TIME_W-1:0]    hit_time,
    input  logic                           last_in_pulse,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [wchc_pkg::POS_W-1:0]     x_position,
    output logic [wchc_pkg::POS_W-1:0]     y_position,
    output logic [wchc_pkg::TIME_W-1:0]    event_time,
    input  logic                           cfg_write,
    input  logic [wchc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wchc_pkg::CFG_W-1:0]     cfg_data
);
    import wchc_pkg::*;

    localparam int Q_W    = (CHARGE_BITS < CHARGE_W) ? CHARGE_BITS : CHARGE_W;
    localparam int QSUM_W = Q_W + $clog2(MAX_AXIS_HITS + 1);
    localparam int WSUM_W = QSUM_W + CHANNEL_W;

    // Configuration registers.
    logic [GAP_W-1:0]     gap_limit_reg;
    logic [CHANNEL_W-1:0] y_base_reg;
    logic [HITS_W-1:0]    min_hits_reg;
    logic [HITS_W-1:0]    max_hits_reg;

    state_t state_reg, state_next;

    accum_ctrl_t   ctrl;
    accum_status_t status;

    logic [WSUM_W-1:0]    snap_xw, snap_yw;
    logic [QSUM_W-1:0]    snap_xq, snap_yq;
    logic [TIME_BITS-1:0] snap_time;

    logic              div_start;
    logic              div_sel_y;
    logic [WSUM_W-1:0] div_num;
    logic [QSUM_W-1:0] div_den;
    logic              div_busy;
    logic [POS_W-1:0]  div_quotient;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic              x_take;
    logic [POS_W-1:0]  x_pos_reg;

    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  x_out_reg, y_out_reg;
    logic [TIME_W-1:0] t_out_reg;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg <= GAP_LIMIT_RESET;
            y_base_reg    <= Y_BASE_RESET;
            min_hits_reg  <= MIN_HITS_RESET;
            max_hits_reg  <= MAX_HITS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAP_LIMIT: gap_limit_reg <= cfg_data[GAP_W-1:0];
                REG_Y_BASE:    y_base_reg    <= cfg_data[CHANNEL_W-1:0];
                REG_MIN_HITS:  min_hits_reg  <= cfg_data[HITS_W-1:0];
                REG_MAX_HITS:  max_hits_reg  <= cfg_data[HITS_W-1:0];
            endcase
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                state_next = (status.emit || status.close_hit) ? ST_START_X : ST_IDLE;
            end
            ST_START_X:
            begin
                state_next = ST_WAIT_X;
            end
            ST_WAIT_X:
            begin
                if (!div_busy)
                begin
                    state_next = ST_START_Y;
                end
            end
            ST_START_Y:
            begin
                state_next = ST_WAIT_Y;
            end
            ST_WAIT_Y:
            begin
                if (!div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        ctrl       = '0;
        div_start  = 1'b0;
        div_sel_y  = 1'b0;
        x_take     = 1'b0;
        out_load   = 1'b0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                ctrl.load = in_valid;
            end
            ST_ADD:     ctrl.add = 1'b1;
            ST_CLOSE:   ctrl.close = 1'b1;
            ST_START_X: div_start = 1'b1;
            ST_WAIT_X:  x_take = !div_busy;
            ST_START_Y:
            begin
                div_start = 1'b1;
                div_sel_y = 1'b1;
            end
            ST_WAIT_Y:  div_sel_y = 1'b1;
            ST_OUT:     out_load = out_free;
            default:    in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Divider operands: X sums first, then Y sums.
    assign div_num = div_sel_y ? snap_yw : snap_xw;
    assign div_den = div_sel_y ? snap_yq : snap_xq;

    wchc_accum #(
        .MAX_AXIS_HITS (MAX_AXIS_HITS),
        .CHARGE_BITS   (CHARGE_BITS),
        .TIME_BITS     (TIME_BITS),
        .QSUM_W        (QSUM_W),
        .WSUM_W        (WSUM_W)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .channel       (channel),
        .charge        (charge),
        .hit_time      (hit_time),
        .last_in_pulse (last_in_pulse),
        .gap_limit     (gap_limit_reg),
        .y_base        (y_base_reg),
        .min_hits      (min_hits_reg),
        .max_hits      (max_hits_reg),
        .status        (status),
        .snap_xw       (snap_xw),
        .snap_xq       (snap_xq),
        .snap_yw       (snap_yw),
        .snap_yq       (snap_yq),
        .snap_time     (snap_time)
    );

    wchc_div #(
        .NUM_W (WSUM_W),
        .DEN_W (QSUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Output beat register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_take)
        begin
            x_pos_reg <= div_quotient;
        end
        if (out_load)
        begin
            x_out_reg <= x_pos_reg;
            y_out_reg <= div_quotient;
            t_out_reg <= TIME_W'(snap_time);
        end
    end

    assign out_valid  = out_valid_reg;
    assign x_position = x_out_reg;
    assign y_position = y_out_reg;
    assign event_time = t_out_reg;

    // A new output beat appears only from the output state.
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("output beat raised outside the output state");

    // The divider is never restarted while it is still iterating.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // An accepted hit is always added in the following cycle.
    a_hit_added: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_ADD)
        else $error("accepted hit not added");

endmodule

/* design/wchc_div.sv */
// Shared restoring divider for the centroid positions, one quotient bit
// per cycle. The quotient is known to fit in POS_W bits.
// Depends on wchc_pkg.
module wchc_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NUM_W-1:0]         num,
    input  logic [DEN_W-1:0]         den,
    output logic                     busy,
    output logic [wchc_pkg::POS_W-1:0] quotient
);
    import wchc_pkg::*;

    localparam int SH_W   = DEN_W + POS_W - 1;
    localparam int W      = (NUM_W > SH_W) ? NUM_W : SH_W;
    localparam int STEP_W = (POS_W > 1) ? $clog2(POS_W) : 1;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      dsh_reg, dsh_next;
    logic [POS_W-1:0]  quo_reg, quo_next;
    logic              fits;

    // One compare and subtract against the shifted divisor per cycle.
    always_comb
    begin
        fits      = (rem_reg >= dsh_reg);
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(POS_W - 1);
            rem_next  = W'(num);
            dsh_next  = W'(den) << (POS_W - 1);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[POS_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* design/wchc_accum.sv */
// Cluster accumulator: holds the hit in work, the open cluster's per-axis
// counts and sums, and the snapshot of a closed cluster that gives an event.
// Depends on wchc_pkg.
module wchc_accum #(
    parameter int MAX_AXIS_HITS = 10,
    parameter int CHARGE_BITS   = 16,
    parameter int TIME_BITS     = 32,
    parameter int QSUM_W        = 20,
    parameter int WSUM_W        = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wchc_pkg::accum_ctrl_t         ctrl,
    input  logic [wchc_pkg::CHANNEL_W-1:0] channel,
    input  logic [wchc_pkg::CHARGE_W-1:0] charge,
    input  logic [wchc_pkg::TIME_W-1:0]   hit_time,
    input  logic                          last_in_pulse,
    input  logic [wchc_pkg::GAP_W-1:0]    gap_limit,
    input  logic [wchc_pkg::CHANNEL_W-1:0] y_base,
    input  logic [wchc_pkg::HITS_W-1:0]   min_hits,
    input  logic [wchc_pkg::HITS_W-1:0]   max_hits,
    output wchc_pkg::accum_status_t       status,
    output logic [WSUM_W-1:0]             snap_xw,
    output logic [QSUM_W-1:0]             snap_xq,
    output logic [WSUM_W-1:0]             snap_yw,
    output logic [QSUM_W-1:0]             snap_yq,
    output logic [TIME_BITS-1:0]          snap_time
);
    import wchc_pkg::*;

    localparam int Q_W    = (CHARGE_BITS < CHARGE_W) ? CHARGE_BITS : CHARGE_W;
    localparam int T_W    = TIME_BITS;
    localparam int D_W    = (T_W > GAP_W) ? T_W : GAP_W;
    localparam int PROD_W = CHANNEL_W + Q_W;
    localparam int AC_W   = $clog2(MAX_AXIS_HITS + 2);
    localparam int TC_W   = $clog2(2 * MAX_AXIS_HITS + 2);
    localparam int CMP_W  = (TC_W > HITS_W) ? TC_W : HITS_W;
    localparam logic [AC_W-1:0] AXIS_MAX = AC_W'(MAX_AXIS_HITS);
    localparam logic [AC_W-1:0] AXIS_SAT = AC_W'(MAX_AXIS_HITS + 1);
    localparam logic [TC_W-1:0] TOTAL_SAT = TC_W'(2 * MAX_AXIS_HITS + 1);

    // Hit in work.
    logic [CHANNEL_W-1:0] ch_reg;
    logic [Q_W-1:0]       q_reg;
    logic [T_W-1:0]       t_reg;
    logic                 last_reg;

    // Cluster state.
    logic              open_reg, open_next;
    logic [T_W-1:0]    ltime_reg, ltime_next;
    logic [TC_W-1:0]   total_reg, total_next;
    logic [AC_W-1:0]   xcnt_reg, xcnt_next;
    logic [AC_W-1:0]   ycnt_reg, ycnt_next;
    logic [WSUM_W-1:0] xw_reg, xw_next;
    logic [QSUM_W-1:0] xq_reg, xq_next;
    logic [WSUM_W-1:0] yw_reg, yw_next;
    logic [QSUM_W-1:0] yq_reg, yq_next;
    logic              emit_reg, emit_next;
    logic              snap_take;

    logic [T_W-1:0]       diff;
    logic                 gap;
    logic                 cur_valid;
    logic                 keep;
    logic                 is_x;
    logic [CHANNEL_W-1:0] pos;
    logic [PROD_W-1:0]    prod;
    logic [TC_W-1:0]      base_total;
    logic [AC_W-1:0]      base_x, base_y;
    logic [WSUM_W-1:0]    base_xw, base_yw;
    logic [QSUM_W-1:0]    base_xq, base_yq;
    logic [CMP_W-1:0]     tot_c;

    // Whether the open cluster, as it stands, qualifies for an event.
    always_comb
    begin
        tot_c     = CMP_W'(total_reg);
        cur_valid = (tot_c >= CMP_W'(min_hits)) && (tot_c <= CMP_W'(max_hits)) &&
                    (xcnt_reg != '0) && (xcnt_reg <= AXIS_MAX) &&
                    (ycnt_reg != '0) && (ycnt_reg <= AXIS_MAX) &&
                    (xq_reg != '0) && (yq_reg != '0);
    end

    // Gap test, hit position and its charge-weighted term.
    always_comb
    begin
        diff = (t_reg >= ltime_reg) ? (t_reg - ltime_reg) : (ltime_reg - t_reg);
        gap  = open_reg && (D_W'(diff) >= D_W'(gap_limit));
        keep = open_reg && !gap;
        is_x = (ch_reg < y_base);
        pos  = is_x ? ch_reg : (ch_reg - y_base);
        prod = PROD_W'(pos) * PROD_W'(q_reg);
    end

    // Next cluster state for the add and close steps.
    always_comb
    begin
        open_next  = open_reg;
        ltime_next = ltime_reg;
        total_next = total_reg;
        xcnt_next  = xcnt_reg;
        ycnt_next  = ycnt_reg;
        xw_next    = xw_reg;
        xq_next    = xq_reg;
        yw_next    = yw_reg;
        yq_next    = yq_reg;
        emit_next  = emit_reg;
        snap_take  = 1'b0;

        base_total = keep ? total_reg : '0;
        base_x     = keep ? xcnt_reg : '0;
        base_y     = keep ? ycnt_reg : '0;
        base_xw    = keep ? xw_reg : '0;
        base_xq    = keep ? xq_reg : '0;
        base_yw    = keep ? yw_reg : '0;
        base_yq    = keep ? yq_reg : '0;

        status.emit      = emit_reg;
        status.close_hit = ctrl.close && last_reg && cur_valid && !emit_reg;

        if (ctrl.add)
        begin
            // A gap closes the old cluster first; then the hit is added.
            emit_next = gap && cur_valid;
            snap_take = gap && cur_valid;
            total_next = (base_total < TOTAL_SAT) ? base_total + 1'b1 : base_total;
            xcnt_next = base_x;
            ycnt_next = base_y;
            xw_next   = base_xw;
            xq_next   = base_xq;
            yw_next   = base_yw;
            yq_next   = base_yq;
            if (is_x)
            begin
                if (base_x < AXIS_MAX)
                begin
                    xw_next   = base_xw + WSUM_W'(prod);
                    xq_next   = base_xq + QSUM_W'(q_reg);
                    xcnt_next = base_x + 1'b1;
                end
                else
                begin
                    xcnt_next = AXIS_SAT;
                end
            end
            else
            begin
                if (base_y < AXIS_MAX)
                begin
                    yw_next   = base_yw + WSUM_W'(prod);
                    yq_next   = base_yq + QSUM_W'(q_reg);
                    ycnt_next = base_y + 1'b1;
                end
                else
                begin
                    ycnt_next = AXIS_SAT;
                end
            end
            ltime_next = t_reg;
            open_next  = 1'b1;
        end
        else if (ctrl.close && last_reg)
        begin
            // The last hit of the pulse closes its cluster.
            if (status.close_hit)
            begin
                emit_next = 1'b1;
                snap_take = 1'b1;
            end
            total_next = '0;
            xcnt_next  = '0;
            ycnt_next  = '0;
            xw_next    = '0;
            xq_next    = '0;
            yw_next    = '0;
            yq_next    = '0;
            open_next  = 1'b0;
        end
    end

    // Cluster state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            ltime_reg <= '0;
            total_reg <= '0;
            xcnt_reg  <= '0;
            ycnt_reg  <= '0;
            xw_reg    <= '0;
            xq_reg    <= '0;
            yw_reg    <= '0;
            yq_reg    <= '0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            open_reg  <= open_next;
            ltime_reg <= ltime_next;
            total_reg <= total_next;
            xcnt_reg  <= xcnt_next;
            ycnt_reg  <= ycnt_next;
            xw_reg    <= xw_next;
            xq_reg    <= xq_next;
            yw_reg    <= yw_next;
            yq_reg    <= yq_next;
            emit_reg  <= emit_next;
        end
    end

    // Hit capture and closed-cluster snapshot.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            ch_reg   <= channel;
            q_reg    <= charge[Q_W-1:0];
            t_reg    <= hit_time[T_W-1:0];
            last_reg <= last_in_pulse;
        end
        if (snap_take)
        begin
            snap_xw   <= xw_reg;
            snap_xq   <= xq_reg;
            snap_yw   <= yw_reg;
            snap_yq   <= yq_reg;
            snap_time <= ltime_reg;
        end
    end

endmodule
